/* src/clamped_detail_sharpen_macros.svh */
// Assertion macros shared by the sharpening block.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef CLAMPED_DETAIL_SHARPEN_MACROS_SVH
`define CLAMPED_DETAIL_SHARPEN_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CDS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define CDS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* src/cds_pkg.sv */
// Types, constants and the luma function of the detail sharpening block.
// No dependencies; used by cds_lines and clamped_detail_sharpen.
package cds_pkg;

	typedef logic [31:0] pixel_t;

	localparam int CFG_W       = 13;
	localparam int ROW_W       = 12;
	localparam int HEIGHT_MAX  = 4096;
	localparam int FIFO_DEPTH  = 8;
	localparam int FIFO_AW     = 3;
	localparam int CORE_LEVEL  = 16;
	localparam int DELTA_LIMIT = 24;

	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;

	localparam logic [7:0] LUMA_R    = 8'd54;
	localparam logic [7:0] LUMA_G    = 8'd183;
	localparam logic [7:0] LUMA_B    = 8'd19;
	localparam logic [7:0] LUMA_BIAS = 8'd128;

	// Per-request facts fixed when the request is taken.
	// A drain whose pixel is the one just read from the line memory takes its
	// centre from the right column of the window instead of the middle one.
	typedef struct packed {
		logic emit;
		logic interior;
		logic ring2;
		logic last;
		logic right_ctr;
	} emit_info_t;

	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic       last;
	} out_item_t;

	function automatic logic [7:0] luma(input pixel_t px);
		logic [15:0] acc;
		acc = 16'(px[7:0]) * 16'(LUMA_R) + 16'(px[15:8]) * 16'(LUMA_G)
			+ 16'(px[23:16]) * 16'(LUMA_B) + 16'(LUMA_BIAS);
		return acc[15:8];
	endfunction

endpackage

/* src/cds_lines.sv */
// Two line memories and the 3x3 pixel window of the sharpening block.
// Uses cds_pkg for the pixel type.
module cds_lines #(
	parameter int MAX_LINE_WIDTH = 4096,
	parameter int AW = $clog2(MAX_LINE_WIDTH)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	input  logic                   req_pixel,
	input  logic [AW-1:0]          req_col,
	input  cds_pkg::pixel_t        req_data,
	output cds_pkg::pixel_t [8:0]  window
);

	cds_pkg::pixel_t mid_mem [MAX_LINE_WIDTH];
	cds_pkg::pixel_t up_mem  [MAX_LINE_WIDTH];

	cds_pkg::pixel_t rd_mid_q, rd_up_q;
	cds_pkg::pixel_t prev_pix_q, prev_mid_q;
	logic            v_s1, pix_s1, hit_s1;
	logic [AW-1:0]   col_s1;
	cds_pkg::pixel_t data_s1;
	cds_pkg::pixel_t mid_c, up_c;
	cds_pkg::pixel_t [8:0] win_q;

	// A request that reads the column being written back this cycle takes the
	// values from the previous request instead of the stale memory word.
	assign mid_c = hit_s1 ? prev_pix_q : rd_mid_q;
	assign up_c  = hit_s1 ? prev_mid_q : rd_up_q;

	always_ff @(posedge clk) begin
		if (req_valid) begin
			rd_mid_q <= mid_mem[req_col];
			rd_up_q  <= up_mem[req_col];
		end
		if (v_s1 && pix_s1) begin
			mid_mem[col_s1] <= data_s1;
			up_mem[col_s1]  <= mid_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			pix_s1 <= 1'b0;
			hit_s1 <= 1'b0;
		end else begin
			v_s1   <= req_valid;
			pix_s1 <= req_pixel;
			hit_s1 <= req_valid && v_s1 && pix_s1 && (col_s1 == req_col);
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid) begin
			col_s1  <= req_col;
			data_s1 <= req_data;
		end
		if (v_s1) begin
			prev_pix_q <= data_s1;
			prev_mid_q <= mid_c;
			// Columns shift left; the newest column enters on the right.
			win_q[0] <= win_q[1];
			win_q[3] <= win_q[4];
			win_q[6] <= win_q[7];
			win_q[1] <= win_q[2];
			win_q[4] <= win_q[5];
			win_q[7] <= win_q[8];
			win_q[2] <= up_c;
			win_q[5] <= mid_c;
			win_q[8] <= data_s1;
		end
	end

	assign window = win_q;

endmodule

/* src/clamped_detail_sharpen.sv */
// Clamped 3x3 detail sharpening of an RGBA stream, delayed by one line plus one pixel.
// A released pixel passes the memory read, window, luma and residual registers into the output queue.
// Throughput: one request per cycle while s_tready is high; pixels read and write each line memory once.
// An eight-entry output queue lets requests continue while results wait downstream.
// Reset (arst_n low, asynchronous) clears counters, valids and the queue; line memories are not cleared.
// Depends on cds_pkg, cds_lines and clamped_detail_sharpen_macros.svh.
`include "clamped_detail_sharpen_macros.svh"

module clamped_detail_sharpen #(
	parameter int MAX_LINE_WIDTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // red_in, green_in, blue_in, alpha_in
	input  logic        s_tuser,   // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // red_out, green_out, blue_out, alpha_out
	output logic        m_tlast,   // frame_end
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	localparam int AW = $clog2(MAX_LINE_WIDTH);
	localparam int WW = $clog2(MAX_LINE_WIDTH + 1);
	localparam int PW = WW + 1;
	localparam int HW = cds_pkg::CFG_W;
	localparam int RW = cds_pkg::ROW_W;

	logic [HW-1:0] width_q, height_q;
	logic [WW-1:0] weff;
	logic [HW-1:0] heff;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= HW'(640);
			height_q <= HW'(480);
		end else if (cfg_valid) begin
			case (cfg_index)
				cds_pkg::CFG_FRAME_WIDTH:  width_q  <= cfg_data;
				cds_pkg::CFG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0)
			weff = WW'(1);
		else if (width_q > HW'(MAX_LINE_WIDTH))
			weff = WW'(MAX_LINE_WIDTH);
		else
			weff = WW'(width_q);
		if (height_q == '0)
			heff = HW'(1);
		else if (height_q > HW'(cds_pkg::HEIGHT_MAX))
			heff = HW'(cds_pkg::HEIGHT_MAX);
		else
			heff = height_q;
	end

	// ---------------- request control ----------------
	localparam int FIFO_CW = cds_pkg::FIFO_AW + 1;
	logic [AW-1:0] col_q, out_col_q, drain_col_q;
	logic [RW-1:0] row_q, out_row_q;
	logic [PW-1:0] pend_q, pend_inc, wp1;
	logic          acc, is_pix, emit_drn, emit_pix, emit;
	logic          col_wrap, row_wrap, ocol_wrap, orow_wrap, dcol_wrap;
	cds_pkg::emit_info_t info_now, info_s1, info_w, info_a, info_b;
	logic [PW-1:0] qx, wd;
	logic [HW-1:0] qy;
	logic [FIFO_CW-1:0] total;
	logic [FIFO_CW-1:0] fifo_cnt_q;

	assign acc    = s_tvalid && s_tready;
	assign is_pix = (s_tuser == cds_pkg::REQ_PIXEL);
	assign wp1    = PW'(weff) + PW'(1);
	assign pend_inc = (pend_q <= wp1) ? pend_q + PW'(1) : pend_q;
	assign emit_pix = pend_inc > wp1;
	assign emit_drn = (col_q == '0) && (row_q == '0) && (pend_q != '0);
	assign emit     = acc && (is_pix ? emit_pix : emit_drn);

	assign col_wrap  = (WW'(col_q) + WW'(1)) >= weff;
	assign row_wrap  = (HW'(row_q) + HW'(1)) >= heff;
	assign ocol_wrap = (WW'(out_col_q) + WW'(1)) >= weff;
	assign orow_wrap = (HW'(out_row_q) + HW'(1)) >= heff;
	assign dcol_wrap = (WW'(drain_col_q) + WW'(1)) >= weff;

	assign qx = PW'(out_col_q);
	assign wd = PW'(weff);
	assign qy = HW'(out_row_q);

	always_comb begin
		info_now.emit     = emit;
		info_now.last     = ocol_wrap && orow_wrap;
		info_now.interior = (qx >= PW'(2)) && (qy >= HW'(2)) && (qx + PW'(2) < wd)
			&& (HW'(qy + HW'(2)) < heff);
		info_now.ring2    = (qx == PW'(2)) || (qy == HW'(2)) || (qx + PW'(3) == wd)
			|| (qy + HW'(3) == heff);
		// The drained pixel is the word read at drain_col_q when it lies
		// width - 1 - drain_col_q pixels behind the newest one.
		info_now.right_ctr = !is_pix && ((PW'(drain_col_q) + pend_q) == wd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			drain_col_q <= '0;
			pend_q      <= '0;
		end else if (acc) begin
			if (is_pix) begin
				drain_col_q <= '0;
				col_q <= col_wrap ? '0 : col_q + AW'(1);
				if (col_wrap)
					row_q <= row_wrap ? '0 : row_q + RW'(1);
				pend_q <= emit_pix ? pend_inc - PW'(1) : pend_inc;
			end else if (emit_drn) begin
				drain_col_q <= dcol_wrap ? '0 : drain_col_q + AW'(1);
				pend_q <= pend_q - PW'(1);
			end
			if (emit) begin
				out_col_q <= ocol_wrap ? '0 : out_col_q + AW'(1);
				if (ocol_wrap)
					out_row_q <= orow_wrap ? '0 : out_row_q + RW'(1);
			end
		end
	end

	// ---------------- line memories and window ----------------
	cds_pkg::pixel_t [8:0] win;

	cds_lines #(
		.MAX_LINE_WIDTH(MAX_LINE_WIDTH),
		.AW            (AW)
	) u_lines (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(acc && (is_pix || emit_drn)),
		.req_pixel(is_pix),
		.req_col  (is_pix ? col_q : drain_col_q),
		.req_data (s_tdata),
		.window   (win)
	);

	// ---------------- filter pipeline ----------------
	logic [7:0]  lum_a [9];
	logic [7:0]  cmin_a [3], cmax_a [3];
	cds_pkg::pixel_t ctr_a, ctr_b;
	logic signed [13:0] res_b;
	logic signed [6:0]  lo_b, hi_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			info_s1 <= '0;
			info_w  <= '0;
			info_a  <= '0;
			info_b  <= '0;
		end else begin
			info_s1 <= acc ? info_now : '0;
			info_w  <= info_s1;
			info_a  <= info_w;
			info_b  <= info_a;
		end
	end

	always_ff @(posedge clk) begin
		logic [7:0] mn, mx;
		if (info_w.emit) begin
			for (int i = 0; i < 9; i++)
				lum_a[i] <= cds_pkg::luma(win[i]);
			for (int c = 0; c < 3; c++) begin
				mn = win[0][8*c +: 8];
				mx = win[0][8*c +: 8];
				for (int i = 1; i < 9; i++) begin
					if (win[i][8*c +: 8] < mn) mn = win[i][8*c +: 8];
					if (win[i][8*c +: 8] > mx) mx = win[i][8*c +: 8];
				end
				cmin_a[c] <= mn;
				cmax_a[c] <= mx;
			end
			ctr_a <= info_w.right_ctr ? win[5] : win[4];
		end
	end

	always_ff @(posedge clk) begin
		logic [11:0]       sum;
		logic signed [8:0] dl, dh;
		logic signed [6:0] lo, hi;
		if (info_a.emit) begin
			sum = 12'(lum_a[0]) + 12'(lum_a[2]) + 12'(lum_a[6]) + 12'(lum_a[8])
				+ {3'b0, lum_a[1], 1'b0} + {3'b0, lum_a[3], 1'b0}
				+ {3'b0, lum_a[5], 1'b0} + {3'b0, lum_a[7], 1'b0}
				+ {2'b0, lum_a[4], 2'b0};
			res_b <= $signed({2'b00, lum_a[4], 4'b0000}) - $signed({2'b00, sum});
			lo = -7'(cds_pkg::DELTA_LIMIT);
			hi = 7'(cds_pkg::DELTA_LIMIT);
			for (int c = 0; c < 3; c++) begin
				dl = $signed({1'b0, cmin_a[c]}) - $signed({1'b0, ctr_a[8*c +: 8]});
				dh = $signed({1'b0, cmax_a[c]}) - $signed({1'b0, ctr_a[8*c +: 8]});
				if (dl > 9'(lo)) lo = 7'(dl);
				if (dh < 9'(hi)) hi = 7'(dh);
			end
			lo_b  <= lo;
			hi_b  <= hi;
			ctr_b <= ctr_a;
		end
	end

	// Coring, gain, ring halving and overshoot clamp.
	logic [12:0]        mag_abs, mag;
	logic [10:0]        dm;
	logic signed [11:0] delta;
	logic [9:0]         nr, ng, nb;
	cds_pkg::out_item_t push_item;

	always_comb begin
		mag_abs = res_b[13] ? 13'(-res_b) : 13'(res_b);
		mag = (mag_abs > 13'(cds_pkg::CORE_LEVEL)) ? mag_abs - 13'(cds_pkg::CORE_LEVEL) : '0;
		dm  = 11'((mag + 13'd2) >> 2);
		if (info_b.ring2)
			dm = dm >> 1;
		delta = res_b[13] ? -$signed({1'b0, dm}) : $signed({1'b0, dm});
		if (delta < 12'(lo_b)) delta = 12'(lo_b);
		if (delta > 12'(hi_b)) delta = 12'(hi_b);
		nr = 10'({2'b00, ctr_b[7:0]}   + 10'(delta));
		ng = 10'({2'b00, ctr_b[15:8]}  + 10'(delta));
		nb = 10'({2'b00, ctr_b[23:16]} + 10'(delta));
		push_item.alpha = ctr_b[31:24];
		push_item.last  = info_b.last;
		if (info_b.interior) begin
			push_item.red   = nr[7:0];
			push_item.green = ng[7:0];
			push_item.blue  = nb[7:0];
		end else begin
			push_item.red   = ctr_b[7:0];
			push_item.green = ctr_b[15:8];
			push_item.blue  = ctr_b[23:16];
		end
	end

	// ---------------- output queue ----------------
	cds_pkg::out_item_t fifo_q [cds_pkg::FIFO_DEPTH];
	logic [cds_pkg::FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic push, pop;

	assign push = info_b.emit;
	assign pop  = m_tvalid && m_tready;

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + cds_pkg::FIFO_AW'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + cds_pkg::FIFO_AW'(1);
			fifo_cnt_q <= fifo_cnt_q + FIFO_CW'(push) - FIFO_CW'(pop);
		end
	end

	assign m_tvalid = (fifo_cnt_q != '0);
	assign m_tdata  = {fifo_q[rd_ptr_q].alpha, fifo_q[rd_ptr_q].blue,
		fifo_q[rd_ptr_q].green, fifo_q[rd_ptr_q].red};
	assign m_tlast  = fifo_q[rd_ptr_q].last;

	// Every result still in the pipeline has a queue entry reserved for it.
	assign total = fifo_cnt_q + FIFO_CW'(info_s1.emit) + FIFO_CW'(info_w.emit)
		+ FIFO_CW'(info_a.emit) + FIFO_CW'(info_b.emit);
	assign s_tready = total < FIFO_CW'(cds_pkg::FIFO_DEPTH);

	`CDS_ASSERT_NOW(a_credit_bound, 1'b1, total <= FIFO_CW'(cds_pkg::FIFO_DEPTH))
	`CDS_ASSERT_NOW(a_no_overflow,
		push && fifo_cnt_q == FIFO_CW'(cds_pkg::FIFO_DEPTH), pop)
	`CDS_ASSERT_NEXT(a_emit_tracked, emit, info_s1.emit)

endmodule

/* tb/clamped_detail_sharpen_tb.sv */
// Self-checking testbench for clamped_detail_sharpen: random RGBA frames, drain requests
// and frame-size writes, with every output pixel compared against a built-in predictor.
// Depends on cds_pkg and the clamped_detail_sharpen RTL.

class sharpen_tracker;
	localparam int RING = 2 * 4096 + 3;

	logic [31:0] history[RING];
	int wr_pos, in_col, in_row, out_col, out_row, pending;
	int frame_w, frame_h;
	logic [32:0] expected_pixels[$];
	int mismatches;

	function new();
		foreach (history[i]) history[i] = '0;
		wr_pos = 0; in_col = 0; in_row = 0; out_col = 0; out_row = 0; pending = 0;
		frame_w = 640; frame_h = 480;
		mismatches = 0;
	endfunction

	function void set_reg(logic [1:0] idx, logic [12:0] val);
		if (idx == cds_pkg::CFG_FRAME_WIDTH) begin
			frame_w = val;
		end else if (idx == cds_pkg::CFG_FRAME_HEIGHT) begin
			frame_h = val;
		end
	endfunction

	function int width_used();
		return (frame_w < 1) ? 1 : (frame_w > 4096) ? 4096 : frame_w;
	endfunction

	function int height_used();
		return (frame_h < 1) ? 1 : (frame_h > 4096) ? 4096 : frame_h;
	endfunction

	function int luma(logic [31:0] p);
		return (54 * int'(p[7:0]) + 183 * int'(p[15:8]) + 19 * int'(p[23:16]) + 128) / 256;
	endfunction

	function void release_oldest();
		int w, h, base, r, g, b, sum, resid, mag, delta, edge_gap, lo, hi, wgt;
		logic [31:0] ctr, nb;
		int low[3], high[3], v[3];
		logic last;
		w = width_used();
		h = height_used();
		base = (wr_pos + RING - pending) % RING;
		ctr = history[base];
		r = ctr[7:0]; g = ctr[15:8]; b = ctr[23:16];
		last = (out_col + 1 >= w) && (out_row + 1 >= h);
		if (out_col >= 2 && out_row >= 2 && out_col + 2 < w && out_row + 2 < h) begin
			sum = 0;
			for (int c = 0; c < 3; c++) begin
				low[c] = 255;
				high[c] = 0;
			end
			for (int dy = -1; dy <= 1; dy++) begin
				for (int dx = -1; dx <= 1; dx++) begin
					nb = history[(base + 2 * RING + dy * w + dx) % RING];
					wgt = (dx == 0 ? 2 : 1) * (dy == 0 ? 2 : 1);
					sum += luma(nb) * wgt;
					for (int c = 0; c < 3; c++) begin
						if (int'(nb[8*c +: 8]) < low[c]) low[c] = nb[8*c +: 8];
						if (int'(nb[8*c +: 8]) > high[c]) high[c] = nb[8*c +: 8];
					end
				end
			end
			resid = 16 * luma(ctr) - sum;
			mag = (resid < 0 ? -resid : resid) - 16;
			if (mag < 0) mag = 0;
			delta = (mag * 4 + 8) / 16;
			if (resid < 0) delta = -delta;
			edge_gap = out_col;
			if (out_row < edge_gap) edge_gap = out_row;
			if (w - 1 - out_col < edge_gap) edge_gap = w - 1 - out_col;
			if (h - 1 - out_row < edge_gap) edge_gap = h - 1 - out_row;
			// The ring just inside the untouched border gets half strength.
			if (edge_gap == 2) delta = delta / 2;
			v[0] = r; v[1] = g; v[2] = b;
			lo = -24;
			hi = 24;
			for (int c = 0; c < 3; c++) begin
				if (low[c] - v[c] > lo) lo = low[c] - v[c];
				if (high[c] - v[c] < hi) hi = high[c] - v[c];
			end
			if (delta < lo) delta = lo;
			if (delta > hi) delta = hi;
			r += delta; g += delta; b += delta;
		end
		expected_pixels.push_back({last, ctr[31:24], 8'(b), 8'(g), 8'(r)});
		pending--;
		out_col++;
		if (out_col >= w) begin
			out_col = 0;
			out_row++;
			if (out_row >= h) out_row = 0;
		end
	endfunction

	function void note_request(logic req, logic [31:0] pix);
		int w, h;
		w = width_used();
		h = height_used();
		if (req == cds_pkg::REQ_DRAIN) begin
			if (in_col == 0 && in_row == 0 && pending > 0) release_oldest();
			return;
		end
		history[wr_pos] = pix;
		wr_pos = (wr_pos + 1) % RING;
		in_col++;
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
			if (in_row >= h) in_row = 0;
		end
		if (pending <= w + 1) pending++;
		if (pending > w + 1) release_oldest();
	endfunction

	function void check_pixel(logic [31:0] pix, logic last);
		logic [32:0] exp_px;
		if (expected_pixels.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR: unexpected output pixel %h last=%0b", pix, last);
			return;
		end
		exp_px = expected_pixels.pop_front();
		if (exp_px != {last, pix}) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR: pixel mismatch: expected rgba=%h last=%0b, got rgba=%h last=%0b",
					exp_px[31:0], exp_px[32], pix, last);
		end
	endfunction
endclass

module clamped_detail_sharpen_tb;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [12:0] cfg_data;

	sharpen_tracker tracker;
	bit no_idle;
	bit hold_output;
	int random_sent;

	clamped_detail_sharpen DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#30000000;
		$display("clamped_detail_sharpen test failed");
		$finish;
	end

	// Output side: random back-pressure, plus one long hold while the input keeps streaming.
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_output) begin
				m_tready <= 1'b0;
				for (int i = 0; i < 300; i++) @(negedge clk);
				hold_output = 1'b0;
			end
			m_tready <= no_idle || ($urandom_range(0, 99) >= 21);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) tracker.check_pixel(m_tdata, m_tlast);
	end

	task automatic send_request(logic req, logic [31:0] pix);
		if (!no_idle && $urandom_range(0, 99) < 27) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= pix;
		do @(posedge clk); while (!s_tready);
		tracker.note_request(req, pix);
		@(negedge clk);
	endtask

	task automatic write_frame_size(logic [12:0] w, logic [12:0] h);
		cfg_valid <= 1'b1;
		cfg_index <= cds_pkg::CFG_FRAME_WIDTH;
		cfg_data  <= w;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_reg(cds_pkg::CFG_FRAME_WIDTH, w);
		@(negedge clk);
		cfg_index <= cds_pkg::CFG_FRAME_HEIGHT;
		cfg_data  <= h;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_reg(cds_pkg::CFG_FRAME_HEIGHT, h);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mix of noise, flat areas with small ripple, and hard black/white edges.
	function automatic logic [31:0] make_pixel(int style, logic [7:0] level);
		logic [7:0] n;
		case (style)
			0: return $urandom;
			1: begin
				n = level + 8'($urandom_range(0, 15));
				return {8'($urandom), n + 8'($urandom_range(0, 3)), n, n - 8'($urandom_range(0, 3))};
			end
			default: return {8'($urandom), ($urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000)};
		endcase
	endfunction

	// Drain out the tail, then let the pipeline settle before any register write.
	task automatic flush_and_settle();
		while (tracker.pending > 0) send_request(cds_pkg::REQ_DRAIN, $urandom);
		s_tvalid <= 1'b0;
		while (tracker.expected_pixels.size() > 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic run_frames(logic [12:0] w, logic [12:0] h, int frames, int style,
		bit with_noise, bit is_random);
		int total;
		logic [7:0] level;
		write_frame_size(w, h);
		total = tracker.width_used() * tracker.height_used() * frames;
		level = $urandom;
		for (int i = 0; i < total; i++) begin
			// Drain requests mid-frame must be ignored by the block.
			if (with_noise && $urandom_range(0, 99) < 5)
				send_request(cds_pkg::REQ_DRAIN, $urandom);
			send_request(cds_pkg::REQ_PIXEL,
				make_pixel(style < 0 ? $urandom_range(0, 2) : style, level));
			if (is_random) random_sent++;
		end
		flush_and_settle();
	endtask

	initial begin
		logic [7:0] pat;
		tracker = new();
		s_tvalid = 1'b0; s_tdata = '0; s_tuser = cds_pkg::REQ_PIXEL;
		cfg_valid = 1'b0; cfg_index = cds_pkg::CFG_FRAME_WIDTH; cfg_data = '0;
		no_idle = 1'b0; hold_output = 1'b0; random_sent = 0;
		arst_n = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed 5x5 frame: extreme values and a bright centre among mixed neighbours.
		write_frame_size(13'd5, 13'd5);
		for (int i = 0; i < 25; i++) begin
			case (i % 5)
				0: pat = 8'h00;
				1: pat = 8'hFF;
				default: pat = (i == 12) ? 8'hFF : (i % 2 ? 8'h10 : 8'hF0);
			endcase
			send_request(cds_pkg::REQ_PIXEL, {~pat, pat, (i == 7) ? 8'h00 : pat, pat});
		end
		send_request(cds_pkg::REQ_DRAIN, 32'hFFFF_FFFF);
		flush_and_settle();

		// Saturated sizes: zero means one.
		run_frames(13'd0, 13'd0, 3, 0, 1'b1, 1'b0);

		// Long output hold while the input keeps offering pixels.
		hold_output = 1'b1;
		run_frames(13'd9, 13'd8, 2, -1, 1'b0, 1'b0);

		while (random_sent < 430) begin
			run_frames(13'($urandom_range(1, 12)), 13'($urandom_range(1, 9)),
				$urandom_range(1, 3), -1, 1'b1, 1'b1);
			no_idle = (random_sent > 150 && random_sent < 270);
		end
		no_idle = 1'b0;

		s_tvalid <= 1'b0;
		while (tracker.expected_pixels.size() > 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (tracker.mismatches == 0 && tracker.expected_pixels.size() == 0) begin
			$display("clamped_detail_sharpen test passed");
		end else begin
			$display("clamped_detail_sharpen test failed");
		end
		$finish;
	end
endmodule

/* files.f */
+incdir+src
src/cds_pkg.sv
src/cds_lines.sv
src/clamped_detail_sharpen.sv
tb/clamped_detail_sharpen_tb.sv
